[design/spc_pkg.sv]
// shared types and constants for the sprite position and tile coverage block
package spc_pkg;

    // tile grid geometry
    localparam int C_ROW_STRIDE = 32;
    localparam int C_GRID_BITS  = $clog2(C_ROW_STRIDE);
    localparam int C_IDX_W      = 10;
    localparam int C_POS_W      = 11;
    localparam int C_TILE_W     = 7;

    // configuration register indexes
    localparam logic [2:0] C_REG_COCKTAIL  = 3'd0;
    localparam logic [2:0] C_REG_XOFF      = 3'd1;
    localparam logic [2:0] C_REG_XOFF_FLIP = 3'd2;
    localparam logic [2:0] C_REG_VMAX_X    = 3'd3;
    localparam logic [2:0] C_REG_VMAX_Y    = 3'd4;
    localparam logic [2:0] C_REG_COLS      = 3'd5;
    localparam logic [2:0] C_REG_ROWS      = 3'd6;

    // register reset values
    localparam logic [9:0] C_VMAX_X_RST = 10'd511;
    localparam logic [9:0] C_VMAX_Y_RST = 10'd479;
    localparam logic [5:0] C_COLS_RST   = 6'd32;
    localparam logic [5:0] C_ROWS_RST   = 6'd30;

    // position math constants
    localparam logic signed [C_POS_W-1:0] C_X_BIAS    = 11'sd8;
    localparam logic signed [C_POS_W-1:0] C_Y_BASE    = 11'sd480;
    localparam logic signed [C_POS_W-1:0] C_FLIP_X    = 11'sd466;
    localparam logic signed [C_POS_W-1:0] C_FLIP_Y    = 11'sd450;
    localparam logic signed [C_POS_W-1:0] C_WRAP      = 11'sd512;
    localparam logic signed [C_POS_W-1:0] C_CLIP      = -11'sd32;

    // one candidate tile
    typedef struct packed {
        logic signed [C_TILE_W-1:0] row;
        logic signed [C_TILE_W-1:0] col;
    } t_tile_req;

    // candidate test result
    typedef struct packed {
        logic               hit;
        logic [C_IDX_W-1:0] index;
    } t_tile_rsp;

endpackage

[design/spc_tile_unit.sv]
// on-screen test and index forming for one candidate tile
module spc_tile_unit
    import spc_pkg::*;
(
    input  t_tile_req  i_req,
    input  logic [5:0] i_cols,
    input  logic [5:0] i_rows,
    output t_tile_rsp  o_rsp
);

    logic [5:0]                 cols_eff;
    logic [5:0]                 rows_eff;
    logic signed [C_TILE_W-1:0] cols_s;
    logic signed [C_TILE_W-1:0] rows_s;

    // grid size saturates at the row stride
    assign cols_eff = (i_cols > 6'(C_ROW_STRIDE)) ? 6'(C_ROW_STRIDE) : i_cols;
    assign rows_eff = (i_rows > 6'(C_ROW_STRIDE)) ? 6'(C_ROW_STRIDE) : i_rows;
    assign cols_s   = $signed({1'b0, cols_eff});
    assign rows_s   = $signed({1'b0, rows_eff});

    // bounds compare and row-major index
    always_comb begin
        o_rsp.hit   = (i_req.row >= 0) && (i_req.row < rows_s) &&
                      (i_req.col >= 0) && (i_req.col < cols_s);
        o_rsp.index = (C_IDX_W'(i_req.row[C_GRID_BITS-1:0]) << C_GRID_BITS) |
                      C_IDX_W'(i_req.col[C_GRID_BITS-1:0]);
    end

endmodule

[design/sprite_position_tile_coverage_top.sv]
// top level: sprite position decode and tile coverage sequencer
//
// Usage:
//   Pulse start with the three bytes of one sprite entry on i_y_byte,
//   i_attr_byte and i_x_byte; the entry is taken when start is high and busy
//   is low. Results come out one word per cycle on the o_* result ports,
//   each marked by a one-cycle o_strobe; o_last flags the final word of an
//   entry. The receiver cannot stall, so every word is taken as it appears.
//   Registers are written on the cfg channel (i_cfg_valid / o_cfg_ready,
//   ready always high); the user must write them only while the block is idle, as the block itself does not enforce it.
// Sequence:
//   an unused entry (y byte zero) gives its word the cycle after start and
//   never raises busy. Otherwise the S_PREP and S_WRAP setup states decode,
//   offset, wrap and clip the position; a clipped sprite ends there. A drawn
//   sprite then walks its 4, 6 or 9 candidate tiles through one shared
//   tile test unit, one per cycle, and then S_DONE flushes the held word.
// Reset:
//   i_rst_n (synchronous) returns the sequencer to idle, drops the strobe
//   and loads the register defaults.
module sprite_position_tile_coverage_top
    import spc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [7:0]                i_y_byte,
    input  logic [7:0]                i_attr_byte,
    input  logic [7:0]                i_x_byte,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [2:0]                i_cfg_index,
    input  logic [9:0]                i_cfg_data,
    output logic                      o_strobe,
    output logic                      o_visible,
    output logic [5:0]                o_sprite_code,
    output logic                      o_flip_h,
    output logic                      o_flip_v,
    output logic signed [C_POS_W-1:0] o_pos_x,
    output logic signed [C_POS_W-1:0] o_pos_y,
    output logic                      o_tile_valid,
    output logic [C_IDX_W-1:0]        o_tile_id,
    output logic                      o_last
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_WRAP = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // configuration registers
    logic             r_cocktail;
    logic signed [7:0] r_xoff;
    logic signed [7:0] r_xoff_flip;
    logic [9:0]       r_vmax_x;
    logic [9:0]       r_vmax_y;
    logic [5:0]       r_cols;
    logic [5:0]       r_rows;

    // sequencer and item registers
    logic [2:0]                r_state, n_state;
    logic [7:0]                r_yb, n_yb;
    logic [7:0]                r_attr, n_attr;
    logic [7:0]                r_xb, n_xb;
    logic signed [C_POS_W-1:0] r_x, n_x;
    logic signed [C_POS_W-1:0] r_y, n_y;
    logic [5:0]                r_code, n_code;
    logic                      r_fh, n_fh;
    logic                      r_fv, n_fv;
    logic [1:0]                r_dr, n_dr;
    logic [1:0]                r_dc, n_dc;
    logic                      r_pend_v, n_pend_v;
    logic [C_IDX_W-1:0]        r_pend_idx, n_pend_idx;

    // output word registers
    logic                      r_strobe, n_strobe;
    logic                      r_visible, n_visible;
    logic [5:0]                r_code_o, n_code_o;
    logic                      r_fh_o, n_fh_o;
    logic                      r_fv_o, n_fv_o;
    logic signed [C_POS_W-1:0] r_px_o, n_px_o;
    logic signed [C_POS_W-1:0] r_py_o, n_py_o;
    logic                      r_tv_o, n_tv_o;
    logic [C_IDX_W-1:0]        r_ti_o, n_ti_o;
    logic                      r_last_o, n_last_o;

    logic                      accept;
    logic signed [C_POS_W-1:0] xb2;
    logic signed [C_POS_W-1:0] yb2;
    logic signed [C_POS_W-1:0] x_wrap;
    logic signed [C_POS_W-1:0] y_wrap;
    logic signed [C_TILE_W-1:0] c0;
    logic signed [C_TILE_W-1:0] r0;
    logic [1:0]                nc_last;
    logic [1:0]                nr_last;
    t_tile_req                 tile_req;
    t_tile_rsp                 tile_rsp;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cocktail  <= 1'b0;
            r_xoff      <= '0;
            r_xoff_flip <= '0;
            r_vmax_x    <= C_VMAX_X_RST;
            r_vmax_y    <= C_VMAX_Y_RST;
            r_cols      <= C_COLS_RST;
            r_rows      <= C_ROWS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                C_REG_COCKTAIL:  r_cocktail  <= i_cfg_data[0];
                C_REG_XOFF:      r_xoff      <= $signed(i_cfg_data[7:0]);
                C_REG_XOFF_FLIP: r_xoff_flip <= $signed(i_cfg_data[7:0]);
                C_REG_VMAX_X:    r_vmax_x    <= i_cfg_data;
                C_REG_VMAX_Y:    r_vmax_y    <= i_cfg_data;
                C_REG_COLS:      r_cols      <= i_cfg_data[5:0];
                C_REG_ROWS:      r_rows      <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // scaled raw bytes
    assign xb2 = $signed({2'b00, r_xb, 1'b0});
    assign yb2 = $signed({2'b00, r_yb, 1'b0});

    // wrap past the visible limits
    assign x_wrap = ($signed({r_x[C_POS_W-1], r_x}) > $signed({2'b00, r_vmax_x})) ?
                    (r_x - C_WRAP) : r_x;
    assign y_wrap = ($signed({r_y[C_POS_W-1], r_y}) > $signed({2'b00, r_vmax_y})) ?
                    (r_y - C_WRAP) : r_y;

    // first covered tile, truncating toward zero, and span per axis
    always_comb begin
        c0 = C_TILE_W'(r_x >>> 4);
        r0 = C_TILE_W'(r_y >>> 4);
        if (r_x[C_POS_W-1] && (r_x[3:0] != 4'd0)) begin
            c0 = c0 + C_TILE_W'(1);
        end
        if (r_y[C_POS_W-1] && (r_y[3:0] != 4'd0)) begin
            r0 = r0 + C_TILE_W'(1);
        end
        nc_last = (r_x[3:0] != 4'd0) ? 2'd2 : 2'd1;
        nr_last = (r_y[3:0] != 4'd0) ? 2'd2 : 2'd1;
    end

    // candidate tile into the shared test unit
    assign tile_req.row = r0 + C_TILE_W'(r_dr);
    assign tile_req.col = c0 + C_TILE_W'(r_dc);

    spc_tile_unit u_tile (
        .i_req  (tile_req),
        .i_cols (r_cols),
        .i_rows (r_rows),
        .o_rsp  (tile_rsp)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_yb       = r_yb;
        n_attr     = r_attr;
        n_xb       = r_xb;
        n_x        = r_x;
        n_y        = r_y;
        n_code     = r_code;
        n_fh       = r_fh;
        n_fv       = r_fv;
        n_dr       = r_dr;
        n_dc       = r_dc;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        n_strobe   = 1'b0;
        n_visible  = r_visible;
        n_code_o   = r_code_o;
        n_fh_o     = r_fh_o;
        n_fv_o     = r_fv_o;
        n_px_o     = r_px_o;
        n_py_o     = r_py_o;
        n_tv_o     = r_tv_o;
        n_ti_o     = r_ti_o;
        n_last_o   = r_last_o;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_yb   = i_y_byte;
                    n_attr = i_attr_byte;
                    n_xb   = i_x_byte;
                    if (i_y_byte == 8'd0) begin
                        // unused entry: zeroed closing word
                        n_strobe  = 1'b1;
                        n_visible = 1'b0;
                        n_code_o  = '0;
                        n_fh_o    = 1'b0;
                        n_fv_o    = 1'b0;
                        n_px_o    = '0;
                        n_py_o    = '0;
                        n_tv_o    = 1'b0;
                        n_ti_o    = '0;
                        n_last_o  = 1'b1;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                // decode, scale and orient
                n_code = r_attr[5:0];
                n_fh   = r_attr[6] ^ r_cocktail;
                n_fv   = r_attr[7] ^ r_cocktail;
                if (r_cocktail) begin
                    n_x = C_FLIP_X - (xb2 - C_X_BIAS) + C_POS_W'(r_xoff_flip);
                    n_y = C_FLIP_Y - (C_Y_BASE - yb2);
                end else begin
                    n_x = xb2 - C_X_BIAS + C_POS_W'(r_xoff);
                    n_y = C_Y_BASE - yb2;
                end
                n_state = S_WRAP;
            end
            S_WRAP: begin
                n_x      = x_wrap;
                n_y      = y_wrap;
                n_dr     = 2'd0;
                n_dc     = 2'd0;
                n_pend_v = 1'b0;
                if ((x_wrap <= C_CLIP) || (y_wrap <= C_CLIP)) begin
                    // clipped sprite
                    n_strobe  = 1'b1;
                    n_visible = 1'b0;
                    n_code_o  = r_code;
                    n_fh_o    = r_fh;
                    n_fv_o    = r_fv;
                    n_px_o    = x_wrap;
                    n_py_o    = y_wrap;
                    n_tv_o    = 1'b0;
                    n_ti_o    = '0;
                    n_last_o  = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // a hit flushes the held word and takes its place
                if (tile_rsp.hit) begin
                    if (r_pend_v) begin
                        n_strobe  = 1'b1;
                        n_visible = 1'b1;
                        n_code_o  = r_code;
                        n_fh_o    = r_fh;
                        n_fv_o    = r_fv;
                        n_px_o    = r_x;
                        n_py_o    = r_y;
                        n_tv_o    = 1'b1;
                        n_ti_o    = r_pend_idx;
                        n_last_o  = 1'b0;
                    end
                    n_pend_v   = 1'b1;
                    n_pend_idx = tile_rsp.index;
                end
                // row-major candidate walk
                if (r_dc == nc_last) begin
                    n_dc = 2'd0;
                    if (r_dr == nr_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_dr = r_dr + 2'd1;
                    end
                end else begin
                    n_dc = r_dc + 2'd1;
                end
            end
            S_DONE: begin
                // final word: held tile or no-tile marker
                n_strobe  = 1'b1;
                n_visible = 1'b1;
                n_code_o  = r_code;
                n_fh_o    = r_fh;
                n_fv_o    = r_fv;
                n_px_o    = r_x;
                n_py_o    = r_y;
                n_tv_o    = r_pend_v;
                n_ti_o    = r_pend_v ? r_pend_idx : '0;
                n_last_o  = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pend_v <= n_pend_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_yb       <= n_yb;
        r_attr     <= n_attr;
        r_xb       <= n_xb;
        r_x        <= n_x;
        r_y        <= n_y;
        r_code     <= n_code;
        r_fh       <= n_fh;
        r_fv       <= n_fv;
        r_dr       <= n_dr;
        r_dc       <= n_dc;
        r_pend_idx <= n_pend_idx;
        r_visible  <= n_visible;
        r_code_o   <= n_code_o;
        r_fh_o     <= n_fh_o;
        r_fv_o     <= n_fv_o;
        r_px_o     <= n_px_o;
        r_py_o     <= n_py_o;
        r_tv_o     <= n_tv_o;
        r_ti_o     <= n_ti_o;
        r_last_o   <= n_last_o;
    end

    assign o_strobe      = r_strobe;
    assign o_visible     = r_visible;
    assign o_sprite_code = r_code_o;
    assign o_flip_h      = r_fh_o;
    assign o_flip_v      = r_fv_o;
    assign o_pos_x       = r_px_o;
    assign o_pos_y       = r_py_o;
    assign o_tile_valid  = r_tv_o;
    assign o_tile_id     = r_ti_o;
    assign o_last        = r_last_o;

endmodule

[design/spc_checker.sv]
// port-level checks for the sprite tile coverage block, with its bind
module spc_checker
    import spc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [7:0]         i_y_byte,
    input logic               o_strobe,
    input logic               o_visible,
    input logic               o_tile_valid,
    input logic [C_IDX_W-1:0] o_tile_id,
    input logic               o_last
);

    // unused entry answers at once with one closing word
    a_unused_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_y_byte == 8'd0) |=> o_strobe && o_last && !o_visible)
        else $error("unused entry did not give a single closing word");

    // a used entry holds the block busy
    a_used_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_y_byte != 8'd0) |=> busy && !o_strobe)
        else $error("used entry did not start the sequencer");

    // hidden sprites give one word only
    a_hidden_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_visible |-> o_last && !o_tile_valid)
        else $error("hidden sprite word is not a lone closing word");

    // tile words come from drawn sprites
    a_tile_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_tile_valid |-> o_visible)
        else $error("tile word without a drawn sprite");

    // no-tile words carry a zero index
    a_no_tile_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_tile_valid |-> (o_tile_id == '0))
        else $error("no-tile word carries a nonzero index");

endmodule

bind sprite_position_tile_coverage_top spc_checker u_spc_checker (.*);
